// ===== design/srmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmb_pkg
// types and constants shared by the serial register monitor bridge
// ----------------------------------------------------------------------------
package srmb_pkg;

    localparam logic [7:0] WIDE_ADDR_A = 8'h84;
    localparam logic [7:0] WIDE_ADDR_B = 8'h8a;
    localparam logic [7:0] WIDE_ADDR_C = 8'h88;

    localparam logic OP_SERIAL    = 1'b0;
    localparam logic OP_READ_DATA = 1'b1;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_ADDR    = 6'b000010,
        PH_READ    = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_DATA_HI = 6'b010000,
        PH_DATA_LO = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic [15:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_address;
        logic        wide;
        logic [15:0] payload;
        logic        last;
    } result_t;

    function automatic logic addr_is_wide(input logic [7:0] addr);
        return (addr == WIDE_ADDR_A) || (addr == WIDE_ADDR_B) || (addr == WIDE_ADDR_C);
    endfunction

endpackage

// ===== design/srmb_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmb_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface srmb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/serial_register_monitor_bridge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_register_monitor_bridge_core
// byte-serial debug bridge into a register bus
//
// items: sink channel of received serial bytes (operation 0) and returned
//   bus read data (operation 1). command byte, address byte, then data
//   bytes for a write; a read issues a bus read request and waits for data.
// results: source channel of transmit bytes, bus writes and bus read
//   requests; last marks the final result of one input transaction.
// results are registered and appear in the cycle after the input transaction.
// throughput: one item per cycle while results are read, when it yields at most
//   one result; a wide read answer yields two transmit bytes, so the next item
//   waits until the first has left; the two-entry result buffer drains one entry a cycle.
// a new item is taken in the same cycle as the last buffered result leaves.
// stall: while results wait unread, no new item is taken; nothing is lost.
// reset: phase returns to idle, held address and data clear, buffer empties.
// items that the current phase does not expect are dropped silently.
// ----------------------------------------------------------------------------
module serial_register_monitor_bridge_core
    import srmb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    srmb_stream_if.sink   items,
    srmb_stream_if.source results
);

    phase_t      phase_reg, phase_next;
    logic        is_write_reg, is_write_next;
    logic [7:0]  held_address_reg, held_address_next;
    logic [7:0]  held_high_byte_reg, held_high_byte_next;

    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    result_t     res0, res1;
    logic [1:0]  res_count;
    logic        addr_wide;
    logic        in_fire, out_fire;
    in_item_t    item;

    assign item     = items.payload;
    assign out_fire = results.valid && results.ready;
    assign items.ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && results.ready);
    assign in_fire  = items.valid && items.ready;

    assign results.valid   = (count_reg != 2'd0);
    assign results.payload = slot0_reg;

    assign addr_wide = addr_is_wide(held_address_next);

    // decode of one item against the current phase
    always_comb
    begin
        phase_next          = phase_reg;
        is_write_next       = is_write_reg;
        held_address_next   = held_address_reg;
        held_high_byte_next = held_high_byte_reg;
        res_count           = 2'd0;
        case (phase_reg)
            PH_READ:
            begin
                if (item.operation == OP_READ_DATA)
                begin
                    phase_next = PH_IDLE;
                    res_count  = addr_is_wide(held_address_reg) ? 2'd2 : 2'd1;
                end
            end
            PH_ADDR:
            begin
                if (item.operation == OP_SERIAL)
                begin
                    held_address_next = item.rx_byte;
                    if (!is_write_reg)
                    begin
                        phase_next = PH_READ;
                        res_count  = 2'd1;
                    end
                    else
                    begin
                        phase_next = addr_is_wide(item.rx_byte) ? PH_DATA_HI : PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (item.operation == OP_SERIAL)
                begin
                    phase_next = PH_IDLE;
                    res_count  = 2'd1;
                end
            end
            PH_DATA_HI:
            begin
                if (item.operation == OP_SERIAL)
                begin
                    held_high_byte_next = item.rx_byte;
                    phase_next          = PH_DATA_LO;
                end
            end
            PH_DATA_LO:
            begin
                if (item.operation == OP_SERIAL)
                begin
                    phase_next = PH_IDLE;
                    res_count  = 2'd1;
                end
            end
            default:
            begin
                if (item.operation == OP_SERIAL)
                begin
                    is_write_next = (item.rx_byte != 8'd0);
                    phase_next    = PH_ADDR;
                end
            end
        endcase
    end

    // result contents
    always_comb
    begin
        res0.kind        = KIND_TX;
        res0.reg_address = held_address_next;
        res0.wide        = addr_wide;
        res0.payload     = 16'd0;
        res0.last        = 1'b1;
        res1.kind        = KIND_TX;
        res1.reg_address = held_address_next;
        res1.wide        = addr_wide;
        res1.payload     = {8'd0, item.read_data[15:8]};
        res1.last        = 1'b1;
        case (phase_reg)
            PH_READ:
            begin
                res0.payload = {8'd0, item.read_data[7:0]};
                res0.last    = !addr_wide;
            end
            PH_ADDR:
            begin
                res0.kind = KIND_READ;
            end
            PH_DATA:
            begin
                res0.kind    = KIND_WRITE;
                res0.payload = {8'd0, item.rx_byte};
            end
            PH_DATA_LO:
            begin
                res0.kind    = KIND_WRITE;
                res0.payload = {held_high_byte_reg, item.rx_byte};
            end
            default:
            begin
                res0.kind = KIND_TX;
            end
        endcase
    end

    // result buffer
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (in_fire)
        begin
            slot0_next = res0;
            slot1_next = res1;
            count_next = res_count;
        end
        else if (out_fire)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            is_write_reg       <= 1'b0;
            held_address_reg   <= 8'd0;
            held_high_byte_reg <= 8'd0;
            count_reg          <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                phase_reg          <= phase_next;
                is_write_reg       <= is_write_next;
                held_address_reg   <= held_address_next;
                held_high_byte_reg <= held_high_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the serial register monitor bridge core: serial
// bytes and returned bus read data go in with random gaps, every result
// transaction is checked field by field against a behavioral bridge model,
// with directed narrow, wide and stray items, then random traffic under
// random backpressure and long receiver hold-offs
// ----------------------------------------------------------------------------
module testbench;
    import srmb_pkg::*;

    localparam int ITEM_TARGET   = 1000;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_OFF_LEN  = 120;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [2:0] {
        BR_IDLE,
        BR_ADDR,
        BR_WAIT_READ,
        BR_WRITE_BYTE,
        BR_WRITE_HIGH,
        BR_WRITE_LOW
    } bridge_phase_t;

    typedef struct {
        in_item_t item;
        int       gap;
    } inbound_t;

    logic clk;
    logic rst_n;

    srmb_stream_if #(.payload_t(in_item_t)) item_ch ();
    srmb_stream_if #(.payload_t(result_t))  result_ch ();

    serial_register_monitor_bridge_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    inbound_t      inbound[$];
    result_t       bridge_responses[$];

    bridge_phase_t br_phase;
    logic          br_is_write;
    logic [7:0]    br_address;
    logic [7:0]    br_high_byte;

    int            error_count;
    int            results_seen;
    int            idle_cycles;
    int            drv_calm;
    int            mon_calm;
    int            gap_left;
    int            hold_left;
    logic          offering;
    inbound_t      sent;
    result_t       want;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic is_wide_reg(input logic [7:0] a);
        case (a)
            WIDE_ADDR_A, WIDE_ADDR_B, WIDE_ADDR_C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm_left = $urandom_range(15, 40);
        return $urandom_range(0, 10);
    endfunction

    function automatic void expect_response(input kind_t k, input logic [15:0] p,
                                            input logic l);
        result_t r;
        r.kind        = k;
        r.reg_address = br_address;
        r.wide        = is_wide_reg(br_address);
        r.payload     = p;
        r.last        = l;
        bridge_responses.push_back(r);
    endfunction

    function automatic void bridge_predict(input in_item_t it);
        if (br_phase == BR_WAIT_READ)
        begin
            if (it.operation == OP_READ_DATA)
            begin
                br_phase = BR_IDLE;
                if (is_wide_reg(br_address))
                begin
                    expect_response(KIND_TX, {8'h00, it.read_data[7:0]}, 1'b0);
                    expect_response(KIND_TX, {8'h00, it.read_data[15:8]}, 1'b1);
                end
                else
                    expect_response(KIND_TX, {8'h00, it.read_data[7:0]}, 1'b1);
            end
        end
        else if (it.operation == OP_SERIAL)
        begin
            case (br_phase)
                BR_ADDR:
                begin
                    br_address = it.rx_byte;
                    if (!br_is_write)
                    begin
                        br_phase = BR_WAIT_READ;
                        expect_response(KIND_READ, 16'h0000, 1'b1);
                    end
                    else if (is_wide_reg(it.rx_byte))
                        br_phase = BR_WRITE_HIGH;
                    else
                        br_phase = BR_WRITE_BYTE;
                end
                BR_WRITE_BYTE:
                begin
                    br_phase = BR_IDLE;
                    expect_response(KIND_WRITE, {8'h00, it.rx_byte}, 1'b1);
                end
                BR_WRITE_HIGH:
                begin
                    br_high_byte = it.rx_byte;
                    br_phase = BR_WRITE_LOW;
                end
                BR_WRITE_LOW:
                begin
                    br_phase = BR_IDLE;
                    expect_response(KIND_WRITE, {br_high_byte, it.rx_byte}, 1'b1);
                end
                default:
                begin
                    br_is_write = (it.rx_byte != 8'h00);
                    br_phase = BR_ADDR;
                end
            endcase
        end
    endfunction

    task automatic add_item(input logic op, input logic [7:0] rx, input logic [15:0] rd);
        inbound_t t;
        t.item.operation = op;
        t.item.rx_byte   = rx;
        t.item.read_data = rd;
        t.gap            = draw_wait(drv_calm);
        inbound.push_back(t);
    endtask

    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1: return WIDE_ADDR_A;
            2: return WIDE_ADDR_B;
            3: return WIDE_ADDR_C;
            4: return WIDE_ADDR_A ^ (8'd1 << $urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        else
        begin
            if (offering && item_ch.ready)
            begin
                sent = inbound.pop_front();
                bridge_predict(sent.item);
                offering = 1'b0;
                gap_left = (inbound.size() != 0) ? inbound[0].gap : 0;
            end
            if (!offering && inbound.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    offering = 1'b1;
                    item_ch.payload <= inbound[0].item;
                end
            end
            item_ch.valid <= offering;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (bridge_responses.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected transaction: kind=%0d addr=%02h wide=%0d",
                                 result_ch.payload.kind, result_ch.payload.reg_address,
                                 result_ch.payload.wide,
                                 " payload=%04h last=%0d",
                                 result_ch.payload.payload, result_ch.payload.last);
                end
                else
                begin
                    want = bridge_responses.pop_front();
                    if (result_ch.payload.kind !== want.kind
                        || result_ch.payload.reg_address !== want.reg_address
                        || result_ch.payload.wide !== want.wide
                        || result_ch.payload.payload !== want.payload
                        || result_ch.payload.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("mismatch: expected kind=%0d addr=%02h wide=%0d",
                                     want.kind, want.reg_address, want.wide,
                                     " payload=%04h last=%0d,",
                                     want.payload, want.last,
                                     " got kind=%0d addr=%02h wide=%0d",
                                     result_ch.payload.kind,
                                     result_ch.payload.reg_address, result_ch.payload.wide,
                                     " payload=%04h last=%0d",
                                     result_ch.payload.payload, result_ch.payload.last);
                    end
                end
                results_seen++;
                // long hold-off so the bridge backs up into its input
                if (results_seen == 150 || results_seen == 400)
                    hold_left = HOLD_OFF_LEN;
                else
                    hold_left = draw_wait(mon_calm);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int         counted;
        int         pick;
        logic [7:0] addr;

        clk             = 1'b0;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        br_phase        = BR_IDLE;
        br_is_write     = 1'b0;
        br_address      = 8'h00;
        br_high_byte    = 8'h00;
        error_count     = 0;
        results_seen    = 0;
        idle_cycles     = 0;
        drv_calm        = 0;
        mon_calm        = 0;
        gap_left        = 0;
        hold_left       = 0;
        offering        = 1'b0;
        counted         = 0;

        // stray read data while idle
        add_item(OP_READ_DATA, 8'hff, 16'hffff);
        // narrow read of address zero, only the low byte goes out
        add_item(OP_SERIAL, 8'h00, 16'h0000);
        add_item(OP_SERIAL, 8'h00, 16'hffff);
        add_item(OP_READ_DATA, 8'h00, 16'hffff);
        // wide reads
        add_item(OP_SERIAL, 8'h00, 16'h0000);
        add_item(OP_SERIAL, WIDE_ADDR_A, 16'h0000);
        add_item(OP_READ_DATA, 8'h00, 16'ha55a);
        add_item(OP_SERIAL, 8'h00, 16'h0000);
        add_item(OP_SERIAL, WIDE_ADDR_C, 16'h0000);
        add_item(OP_SERIAL, 8'h77, 16'hffff);
        add_item(OP_READ_DATA, 8'hff, 16'h0000);
        add_item(OP_SERIAL, 8'h00, 16'h0000);
        add_item(OP_SERIAL, WIDE_ADDR_B, 16'h0000);
        add_item(OP_READ_DATA, 8'h00, 16'hffff);
        // narrow neighbor of a wide address
        add_item(OP_SERIAL, 8'h00, 16'h0000);
        add_item(OP_SERIAL, 8'h85, 16'h0000);
        add_item(OP_READ_DATA, 8'h00, 16'hbeef);
        // narrow write, all ones
        add_item(OP_SERIAL, 8'hff, 16'h0000);
        add_item(OP_SERIAL, 8'hff, 16'h0000);
        add_item(OP_SERIAL, 8'hff, 16'h0000);
        // wide write with stray read data during the address phase
        add_item(OP_SERIAL, 8'h01, 16'h0000);
        add_item(OP_READ_DATA, 8'h55, 16'h1234);
        add_item(OP_SERIAL, WIDE_ADDR_B, 16'h0000);
        add_item(OP_SERIAL, 8'h12, 16'h0000);
        add_item(OP_SERIAL, 8'h34, 16'h0000);

        while (counted < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            addr = pick_address();
            if (pick < 42)
            begin
                add_item(OP_SERIAL, 8'h00, 16'($urandom));
                add_item(OP_SERIAL, addr, 16'($urandom));
                if ($urandom_range(0, 9) == 0)
                    add_item(OP_SERIAL, 8'($urandom), 16'($urandom));
                add_item(OP_READ_DATA, 8'($urandom), 16'($urandom));
                counted += 3;
            end
            else if (pick < 84)
            begin
                add_item(OP_SERIAL, 8'($urandom_range(1, 255)), 16'($urandom));
                add_item(OP_SERIAL, addr, 16'($urandom));
                add_item(OP_SERIAL, 8'($urandom), 16'($urandom));
                counted += 3;
                if (is_wide_reg(addr))
                begin
                    add_item(OP_SERIAL, 8'($urandom), 16'($urandom));
                    counted++;
                end
            end
            else if (pick < 92)
                add_item(OP_READ_DATA, 8'($urandom), 16'($urandom));
            else
            begin
                // broken sequence: a lone serial byte
                add_item(OP_SERIAL, 8'($urandom), 16'($urandom));
                counted++;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (inbound.size() != 0 || bridge_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bridge_responses.size() != 0)
        begin
            error_count++;
            $display("%0d expected transactions never arrived", bridge_responses.size());
        end
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
